// File: rtl/tcw_pkg.sv
package tcw_pkg;

    localparam int MAX_COLS   = 128;
    localparam int MAX_ROWS   = 32;
    localparam int CELL_COUNT = MAX_COLS * MAX_ROWS;

    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int ADDR_W = 12;
    localparam int PTR_W  = 13;   // can hold CELL_COUNT itself

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTR = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TABW = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAGE = 3'd4;

    // register reset values
    localparam logic [7:0]  RST_ATTR = 8'h07;
    localparam logic [4:0]  RST_TABW = 5'd8;
    localparam logic [7:0]  RST_COLS = 8'd80;
    localparam logic [5:0]  RST_ROWS = 6'd25;
    localparam logic [15:0] RST_PAGE = 16'h0000;

    // character codes
    localparam logic [7:0] CH_BS       = 8'h08;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_LF       = 8'h0A;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CH_PRINT_LO = 8'h20;
    localparam logic [7:0] CH_PRINT_HI = 8'h7F;

    typedef struct packed {
        logic                func;
        logic [7:0]          character;
        logic [ADDR_W-1:0]   cell_index;
    } t_req;

    typedef struct packed {
        logic [COL_W-1:0]    cursor_col;
        logic [ROW_W-1:0]    cursor_row;
        logic [15:0]         cursor_position;
        logic [15:0]         read_data;
        logic                scrolled;
    } t_result;

    // operands of the shared multiply-add unit: y = a * b + c
    typedef struct packed {
        logic [5:0]          a;
        logic [7:0]          b;
        logic [15:0]         c;
    } t_mac_op;

endpackage

// File: rtl/tcw_muladd.sv
module tcw_muladd (
    input  logic             i_clk,
    input  tcw_pkg::t_mac_op i_op,
    output logic [15:0]      o_y
);

    logic [13:0] w_prod;
    logic [15:0] n_y;
    logic [15:0] r_y;

    assign w_prod = i_op.a * i_op.b;
    assign n_y    = {2'b00, w_prod} + i_op.c;

    always_ff @(posedge i_clk) begin
        r_y <= n_y;
    end

    assign o_y = r_y;

endmodule

// File: rtl/tcw_tabdiv.sv
module tcw_tabdiv (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [7:0] i_dividend,
    input  logic [4:0] i_divisor,
    output logic       o_done,
    output logic [7:0] o_quot
);

    logic       r_run;
    logic       r_done;
    logic [2:0] r_cnt;
    logic [4:0] r_rem;
    logic [7:0] r_quot;
    logic [4:0] r_div;

    logic [5:0] w_trial;
    logic [5:0] w_diff;
    logic       w_ge;
    logic [4:0] n_rem;

    // restoring division, one quotient bit per cycle
    assign w_trial = {r_rem, r_quot[7]};
    assign w_ge    = (w_trial >= {1'b0, r_div});
    assign w_diff  = w_trial - {1'b0, r_div};
    assign n_rem   = w_ge ? w_diff[4:0] : w_trial[4:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_rem  <= n_rem;
            r_quot <= {r_quot[6:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// File: rtl/tcw_screen.sv
module tcw_screen (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [tcw_pkg::ADDR_W-1:0] i_waddr,
    input  logic [15:0]                i_wdata,
    input  logic                       i_re,
    input  logic [tcw_pkg::ADDR_W-1:0] i_raddr,
    output logic [15:0]                o_rdata
);

    logic [15:0] r_cells [tcw_pkg::CELL_COUNT];
    logic [15:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_cells[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_cells[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/text_console_writer.sv
// Character-cell text screen with a cursor.
// Request channel: a request is taken on a rising edge with start high and busy
// low. func 0 puts a character at the cursor and moves the cursor; func 1 reads
// the cell at cell_index. Each request gives exactly one result on o_result,
// shown for one cycle with o_done high; the receiver must take it then.
// Config port: i_cfg_we / i_cfg_idx / i_cfg_data write one register per edge,
// intended only while busy is low.
// States from the accepting edge to the o_done cycle:
//   read: S_POS, S_DONE; put of an ordinary or control byte: S_ADDR, S_WRITE,
//   S_POS, S_DONE; tab: S_TAB_DIV (8 divider steps), then one multiply-add pass
//   in S_TAB_MUL and S_TAB_CHK before S_POS. A new line past the last row also
//   scrolls: S_TOTAL, S_KEEP, then one read and one write for each cell moved
//   up and one blanking write for each bottom-row cell, before S_POS. The next
//   request is taken at the earliest once the result cycle ends and busy is low.
// All address and position products go through one registered multiply-add unit,
// so items are handled one at a time; busy is high until the result cycle ends.
// Reset: a clearing pass writes zero to all 4096 cells with busy high; config
// writes are still taken. Cursor goes to 0,0 and registers to their defaults.
module text_console_writer (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  tcw_pkg::t_req                 i_req,
    input  logic                          i_cfg_we,
    input  logic [tcw_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [tcw_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output logic                          o_done,
    output tcw_pkg::t_result              o_result
);

    localparam logic [3:0] S_CLEAR   = 4'd0;
    localparam logic [3:0] S_IDLE    = 4'd1;
    localparam logic [3:0] S_ADDR    = 4'd2;
    localparam logic [3:0] S_WRITE   = 4'd3;
    localparam logic [3:0] S_TAB_DIV = 4'd4;
    localparam logic [3:0] S_TAB_MUL = 4'd5;
    localparam logic [3:0] S_TAB_CHK = 4'd6;
    localparam logic [3:0] S_TOTAL   = 4'd7;
    localparam logic [3:0] S_KEEP    = 4'd8;
    localparam logic [3:0] S_SCR_RD  = 4'd9;
    localparam logic [3:0] S_SCR_WR  = 4'd10;
    localparam logic [3:0] S_POS     = 4'd11;
    localparam logic [3:0] S_DONE    = 4'd12;

    // configuration registers
    logic [7:0]  r_attr;
    logic [4:0]  r_tabw;
    logic [7:0]  r_cols;
    logic [5:0]  r_rows;
    logic [15:0] r_page;

    // sequencer state
    logic [3:0]                  r_state, n_state;
    logic [tcw_pkg::COL_W-1:0]   r_col, n_col;
    logic [tcw_pkg::ROW_W-1:0]   r_line, n_line;
    logic                        r_func, n_func;
    logic [7:0]                  r_char, n_char;
    logic [tcw_pkg::PTR_W-1:0]   r_p, n_p;
    logic [tcw_pkg::PTR_W-1:0]   r_total, n_total;
    logic [tcw_pkg::PTR_W-1:0]   r_keep, n_keep;
    logic [15:0]                 r_rdata, n_rdata;
    logic                        r_scr, n_scr;

    // effective geometry
    logic [7:0] w_nc;
    logic [5:0] w_nr;
    logic [4:0] w_tw;

    logic [5:0]                w_line_inc;
    logic                      w_nl_scroll;
    logic [tcw_pkg::ROW_W-1:0] w_nl_line;
    logic [7:0]                w_col_inc;
    logic                      w_printable;

    tcw_pkg::t_mac_op  w_op;
    logic [15:0]       w_y;

    logic                       w_div_done;
    logic [7:0]                 w_quot;
    logic                       w_div_start;
    logic [7:0]                 w_div_arg;

    logic                       w_mem_we;
    logic [tcw_pkg::ADDR_W-1:0] w_mem_waddr;
    logic [15:0]                w_mem_wdata;
    logic                       w_mem_re;
    logic [tcw_pkg::ADDR_W-1:0] w_mem_raddr;
    logic [15:0]                w_mem_rdata;

    assign w_nc = (r_cols == 8'd0) ? 8'd1 :
                  (r_cols > 8'(tcw_pkg::MAX_COLS)) ? 8'(tcw_pkg::MAX_COLS) : r_cols;
    assign w_nr = (r_rows == 6'd0) ? 6'd1 :
                  (r_rows > 6'(tcw_pkg::MAX_ROWS)) ? 6'(tcw_pkg::MAX_ROWS) : r_rows;
    assign w_tw = (r_tabw == 5'd0) ? 5'd1 : r_tabw;

    assign w_line_inc  = {1'b0, r_line} + 6'd1;
    assign w_nl_scroll = (w_line_inc >= w_nr);
    assign w_nl_line   = w_nl_scroll ? 5'(w_nr - 6'd1) : w_line_inc[4:0];
    assign w_col_inc   = {1'b0, r_col} + 8'd1;
    assign w_printable = (r_char >= tcw_pkg::CH_PRINT_LO) && (r_char <= tcw_pkg::CH_PRINT_HI);

    // col + tab width never exceeds 158
    assign w_div_arg = {1'b0, r_col} + {3'b000, w_tw};

    // shared unit operand select
    always_comb begin
        w_op.a = {1'b0, r_line};
        w_op.b = w_nc;
        w_op.c = {9'b0, r_col};
        unique case (r_state)
            S_TAB_MUL: begin
                w_op.a = {1'b0, w_tw};
                w_op.b = w_quot;
                w_op.c = '0;
            end
            S_TOTAL: begin
                w_op.a = w_nr;
                w_op.b = w_nc;
                w_op.c = '0;
            end
            S_POS: begin
                w_op.c = r_page + {9'b0, r_col};
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_col       = r_col;
        n_line      = r_line;
        n_func      = r_func;
        n_char      = r_char;
        n_p         = r_p;
        n_total     = r_total;
        n_keep      = r_keep;
        n_rdata     = r_rdata;
        n_scr       = r_scr;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_p[tcw_pkg::ADDR_W-1:0];
        w_mem_wdata = '0;
        w_mem_re    = 1'b0;
        w_mem_raddr = i_req.cell_index;
        w_div_start = 1'b0;
        unique case (r_state)
            S_CLEAR: begin
                w_mem_we = 1'b1;
                n_p      = r_p + 13'd1;
                if (r_p[tcw_pkg::ADDR_W-1:0] == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_func  = i_req.func;
                    n_char  = i_req.character;
                    n_scr   = 1'b0;
                    n_rdata = '0;
                    if (i_req.func) begin
                        w_mem_re = 1'b1;
                        n_state  = S_POS;
                    end else begin
                        n_state = S_ADDR;
                    end
                end
            end
            S_ADDR: begin
                n_state = S_WRITE;
            end
            S_WRITE: begin
                // w_y holds line * columns + col, always inside the store
                w_mem_we    = w_printable;
                w_mem_waddr = w_y[tcw_pkg::ADDR_W-1:0];
                w_mem_wdata = {r_attr, r_char};
                n_state     = S_POS;
                unique case (r_char)
                    tcw_pkg::CH_LF: begin
                        n_col  = '0;
                        n_line = w_nl_line;
                        n_scr  = w_nl_scroll;
                        if (w_nl_scroll) begin
                            n_state = S_TOTAL;
                        end
                    end
                    tcw_pkg::CH_CR: begin
                        n_col = '0;
                    end
                    tcw_pkg::CH_TAB: begin
                        w_div_start = 1'b1;
                        n_state     = S_TAB_DIV;
                    end
                    tcw_pkg::CH_BS: begin
                        if (r_col != '0) begin
                            n_col = r_col - 7'd1;
                        end
                    end
                    default: begin
                        if (w_col_inc >= w_nc) begin
                            n_col  = '0;
                            n_line = w_nl_line;
                            n_scr  = w_nl_scroll;
                            if (w_nl_scroll) begin
                                n_state = S_TOTAL;
                            end
                        end else begin
                            n_col = w_col_inc[6:0];
                        end
                    end
                endcase
            end
            S_TAB_DIV: begin
                if (w_div_done) begin
                    n_state = S_TAB_MUL;
                end
            end
            S_TAB_MUL: begin
                n_state = S_TAB_CHK;
            end
            S_TAB_CHK: begin
                // w_y is the next tab stop
                n_state = S_POS;
                if (w_y >= {8'b0, w_nc}) begin
                    n_col  = '0;
                    n_line = w_nl_line;
                    n_scr  = w_nl_scroll;
                    if (w_nl_scroll) begin
                        n_state = S_TOTAL;
                    end
                end else begin
                    n_col = w_y[6:0];
                end
            end
            S_TOTAL: begin
                n_state = S_KEEP;
            end
            S_KEEP: begin
                n_total = w_y[tcw_pkg::PTR_W-1:0];
                n_keep  = w_y[tcw_pkg::PTR_W-1:0] - {5'b0, w_nc};
                n_p     = '0;
                n_state = S_SCR_RD;
            end
            S_SCR_RD: begin
                if (r_p < r_keep) begin
                    w_mem_re    = 1'b1;
                    w_mem_raddr = 12'(r_p + {5'b0, w_nc});
                    n_state     = S_SCR_WR;
                end else if (r_p < r_total) begin
                    // blank bottom row
                    w_mem_we    = 1'b1;
                    w_mem_wdata = {r_attr, 8'h00};
                    n_p         = r_p + 13'd1;
                end else begin
                    n_state = S_POS;
                end
            end
            S_SCR_WR: begin
                w_mem_we    = 1'b1;
                w_mem_wdata = w_mem_rdata;
                n_p         = r_p + 13'd1;
                n_state     = S_SCR_RD;
            end
            S_POS: begin
                if (r_func) begin
                    n_rdata = w_mem_rdata;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_col   <= '0;
            r_line  <= '0;
            r_p     <= '0;
            r_scr   <= 1'b0;
            r_func  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            r_line  <= n_line;
            r_p     <= n_p;
            r_scr   <= n_scr;
            r_func  <= n_func;
        end
    end

    always_ff @(posedge i_clk) begin
        r_char  <= n_char;
        r_total <= n_total;
        r_keep  <= n_keep;
        r_rdata <= n_rdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attr <= tcw_pkg::RST_ATTR;
            r_tabw <= tcw_pkg::RST_TABW;
            r_cols <= tcw_pkg::RST_COLS;
            r_rows <= tcw_pkg::RST_ROWS;
            r_page <= tcw_pkg::RST_PAGE;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tcw_pkg::REG_ATTR: r_attr <= i_cfg_data[7:0];
                tcw_pkg::REG_TABW: r_tabw <= i_cfg_data[4:0];
                tcw_pkg::REG_COLS: r_cols <= i_cfg_data[7:0];
                tcw_pkg::REG_ROWS: r_rows <= i_cfg_data[5:0];
                tcw_pkg::REG_PAGE: r_page <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tcw_muladd u_muladd (
        .i_clk (i_clk),
        .i_op  (w_op),
        .o_y   (w_y)
    );

    tcw_tabdiv u_tabdiv (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_arg),
        .i_divisor  (w_tw),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    tcw_screen u_screen (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_waddr (w_mem_waddr),
        .i_wdata (w_mem_wdata),
        .i_re    (w_mem_re),
        .i_raddr (w_mem_raddr),
        .o_rdata (w_mem_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign o_done = (r_state == S_DONE);

    assign o_result.cursor_col      = r_col;
    assign o_result.cursor_row      = r_line;
    assign o_result.cursor_position = w_y;
    assign o_result.read_data       = r_rdata;
    assign o_result.scrolled        = r_scr;

endmodule

// File: rtl/tcw_checker.sv
module tcw_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic             o_done,
    input tcw_pkg::t_result o_result
);

    // results only come out while a request is in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe while idle");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!busy && !start) |=> (!busy && !o_done))
        else $error("left idle without a request");

    a_scroll_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.scrolled) |-> (o_result.cursor_col == '0))
        else $error("scroll without cursor at column zero");

    // clearing pass follows reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("not busy after reset");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (.*);
